### hw/rtl/bpu_pkg.sv
// Shared types and constants for the BMP pixel unpacker.
// No dependencies; imported by every module of the block.
package bpu_pkg;

  localparam int unsigned HdrLen = 54;

  // Header byte positions (low six bits of the byte counter)
  localparam logic [5:0] PosSigB     = 6'd0;
  localparam logic [5:0] PosSigM     = 6'd1;
  localparam logic [5:0] PosOffset   = 6'd13;
  localparam logic [5:0] PosWidth    = 6'd21;
  localparam logic [5:0] PosHeight   = 6'd25;
  localparam logic [5:0] PosPlanes   = 6'd27;
  localparam logic [5:0] PosDepth    = 6'd29;
  localparam logic [5:0] PosCompress = 6'd33;
  localparam logic [5:0] PosHdrEnd   = 6'd53;

  localparam logic [7:0]  SigB      = 8'h42;
  localparam logic [7:0]  SigM      = 8'h4D;
  localparam logic [15:0] PlanesOne = 16'd1;
  localparam logic [15:0] Depth24   = 16'd24;
  localparam logic [15:0] Depth32   = 16'd32;
  localparam logic [31:0] BiRgb     = 32'd0;

  // Pixel byte phases
  localparam logic [1:0] PhBlue  = 2'd0;
  localparam logic [1:0] PhGreen = 2'd1;
  localparam logic [1:0] PhRed   = 2'd2;
  localparam logic [1:0] PhAlpha = 2'd3;

  typedef struct packed {
    logic hdr_phase;  // byte counter still inside the 54-byte header
    logic data_ok;    // header good and counter at or past the data offset
    logic four_byte;  // 32-bit pixels
    logic status;     // header failure result on this transfer
  } hdr_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [23:0] index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } pix_res_t;

endpackage

### hw/rtl/bpu_hdr.sv
// Header parser: byte counter, little-endian field shifter and header checks.
// Depends on bpu_pkg.
module bpu_hdr import bpu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  output hdr_ctl_t      ctl_o,
  output logic [WW-1:0] width_o,
  output logic [HW-1:0] height_o
);

  logic [31:0]   count_q, offset_q, acc_q, acc_d;
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic          four_q, failed_q, bad_q;
  logic          in_hdr, at_end;

  assign in_hdr = count_q < 32'(HdrLen);
  assign at_end = in_hdr && (count_q[5:0] == PosHdrEnd);
  assign acc_d  = {data_i, acc_q[31:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      offset_q <= '0;
      acc_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      four_q   <= 1'b0;
      failed_q <= 1'b0;
      bad_q    <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        count_q  <= '0;
        offset_q <= '0;
        acc_q    <= '0;
        width_q  <= '0;
        height_q <= '0;
        four_q   <= 1'b0;
        failed_q <= 1'b0;
        bad_q    <= 1'b0;
      end else begin
        if (count_q != '1) begin
          count_q <= count_q + 32'd1;
        end
        if (in_hdr) begin
          acc_q <= acc_d;
          unique case (count_q[5:0])
            PosSigB: if (data_i != SigB) bad_q <= 1'b1;
            PosSigM: if (data_i != SigM) bad_q <= 1'b1;
            PosOffset: begin
              offset_q <= acc_d;
              if (acc_d < 32'(HdrLen)) bad_q <= 1'b1;
            end
            PosWidth: begin
              if (acc_d[31] || acc_d > 32'(MAX_WIDTH)) bad_q <= 1'b1;
              else width_q <= acc_d[WW-1:0];
            end
            PosHeight: begin
              if (acc_d[31] || acc_d > 32'(MAX_HEIGHT)) bad_q <= 1'b1;
              else height_q <= acc_d[HW-1:0];
            end
            PosPlanes: if (acc_d[31:16] != PlanesOne) bad_q <= 1'b1;
            PosDepth: begin
              if (acc_d[31:16] == Depth24) four_q <= 1'b0;
              else if (acc_d[31:16] == Depth32) four_q <= 1'b1;
              else bad_q <= 1'b1;
            end
            PosCompress: if (acc_d != BiRgb) bad_q <= 1'b1;
            PosHdrEnd: if (bad_q) failed_q <= 1'b1;
            default: ;
          endcase
        end
      end
    end
  end

  assign ctl_o.hdr_phase = in_hdr;
  assign ctl_o.data_ok   = !failed_q && (count_q >= offset_q);
  assign ctl_o.four_byte = four_q;
  // one failure result at the header end, or on a file cut short before it
  assign ctl_o.status    = step_i && ((at_end && bad_q) || (last_i && in_hdr && !at_end));
  assign width_o         = width_q;
  assign height_o        = height_q;

endmodule

### hw/rtl/bpu_walker.sv
// Pixel walker: byte phase, column, padding and row counters, top-down index.
// Depends on bpu_pkg.
module bpu_walker import bpu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  input  hdr_ctl_t      ctl_i,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  output pix_res_t      pix_o
);

  logic [HW-1:0] row_q;
  logic [WW-1:0] col_q, col_inc;
  logic [1:0]    phase_q, pad_q, pad_need;
  logic [23:0]   hold_q, hold_d, base_q, base_prod;
  logic [WW+1:0] width_ext;
  logic          active, in_line, last_k, row_end;

  assign width_ext = {2'b00, width_i};
  // 24-bit rows pad by width mod 4 bytes, 32-bit rows never pad
  assign pad_need  = ctl_i.four_byte ? 2'd0 : width_ext[1:0];
  assign active    = step_i && !ctl_i.hdr_phase && ctl_i.data_ok &&
                     (row_q < height_i) && (width_i != '0);
  assign in_line   = col_q < width_i;
  assign last_k    = ctl_i.four_byte ? (phase_q == PhAlpha) : (phase_q == PhRed);
  assign col_inc   = col_q + WW'(1);
  assign row_end   = in_line ? (last_k && (col_inc == width_i) && (pad_need == 2'd0))
                             : ((pad_q + 2'd1) == pad_need);
  assign base_prod = (24'(height_i) - 24'd1) * 24'(width_i);

  always_comb begin
    unique case (phase_q)
      PhBlue:  hold_d = {16'd0, data_i};
      PhGreen: hold_d = {hold_q[23:16], data_i, hold_q[7:0]};
      PhRed:   hold_d = {data_i, hold_q[15:0]};
      PhAlpha: hold_d = hold_q;
      default: hold_d = hold_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      phase_q <= PhBlue;
      pad_q   <= '0;
    end else if (step_i && last_i) begin
      row_q   <= '0;
      col_q   <= '0;
      phase_q <= PhBlue;
      pad_q   <= '0;
    end else if (active) begin
      if (row_end) begin
        row_q   <= row_q + HW'(1);
        col_q   <= '0;
        phase_q <= PhBlue;
        pad_q   <= '0;
      end else if (in_line) begin
        if (last_k) begin
          col_q   <= col_inc;
          phase_q <= PhBlue;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end else begin
        pad_q <= pad_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active && in_line) begin
      hold_q <= hold_d;
    end
    if (ctl_i.hdr_phase) begin
      base_q <= base_prod;
    end else if (active && row_end) begin
      base_q <= base_q - 24'(width_i);
    end
  end

  assign pix_o.valid = active && in_line && last_k;
  assign pix_o.index = base_q + 24'(col_q);
  assign pix_o.red   = hold_d[23:16];
  assign pix_o.green = hold_d[15:8];
  assign pix_o.blue  = hold_d[7:0];
  assign pix_o.alpha = ctl_i.four_byte ? data_i : 8'd0;

endmodule

### hw/rtl/bmp_pixel_unpacker_unit.sv
// Top level of the BMP pixel unpacker: input register, header parser,
// pixel walker and result register. Depends on bpu_pkg, bpu_hdr, bpu_walker.
//
// Takes an uncompressed BMP file one byte per transfer and returns RGB(A)
// pixels with a top-down frame index. The 54-byte header is parsed on the fly:
// signature, pixel-data offset, width, height, planes, depth (24 or 32) and
// compression (BI_RGB only); a bad or oversized header gives one result with
// status set, then bytes are dropped until the byte marked last_of_image,
// after which parsing restarts. A file that ends before the header does also
// gives one status result. Rate: one byte per clock cycle, sustained; a byte
// goes via the input register to the result register; the only stall is
// a held result register (out_ready_i low), which backs up through the
// single input register. Each input byte yields at most one result: a pixel
// appears on its last byte (third or fourth). Pixel index is computed with
// one multiply at the header end and then one subtract per row, so no
// per-byte divide or multiply is needed. MAX_WIDTH and MAX_HEIGHT bound the
// accepted image size and set the counter widths.
module bmp_pixel_unpacker_unit import bpu_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_image_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] pixel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        has_alpha_o,
  output logic        status_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  // input register
  logic       in_vld_q, last_q;
  logic [7:0] byte_q;
  // result register
  logic        out_vld_q, has_alpha_q, status_q;
  logic [23:0] index_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;

  logic          step, emit;
  hdr_ctl_t      hdr_ctl;
  pix_res_t      pix;
  logic [WW-1:0] width;
  logic [HW-1:0] height;

  // process the held byte when the result register can take a result
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign emit       = hdr_ctl.status || pix.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_of_image_i;
    end
  end

  bpu_hdr #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_hdr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .data_i  (byte_q),
    .last_i  (last_q),
    .ctl_o   (hdr_ctl),
    .width_o (width),
    .height_o(height)
  );

  bpu_walker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .data_i  (byte_q),
    .last_i  (last_q),
    .ctl_i   (hdr_ctl),
    .width_i (width),
    .height_i(height),
    .pix_o   (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= emit;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // status results carry zero payload
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      if (hdr_ctl.status) begin
        index_q     <= '0;
        red_q       <= '0;
        green_q     <= '0;
        blue_q      <= '0;
        alpha_q     <= '0;
        has_alpha_q <= 1'b0;
        status_q    <= 1'b1;
      end else begin
        index_q     <= pix.index;
        red_q       <= pix.red;
        green_q     <= pix.green;
        blue_q      <= pix.blue;
        alpha_q     <= pix.alpha;
        has_alpha_q <= hdr_ctl.four_byte;
        status_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pixel_index_o = index_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign alpha_o       = alpha_q;
  assign has_alpha_o   = has_alpha_q;
  assign status_o      = status_q;

  // a failure result and a pixel never come from the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hdr_ctl.status && pix.valid))
    else $error("status and pixel result on the same byte");

  // pixels only come out after the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid |-> !hdr_ctl.hdr_phase)
    else $error("pixel produced inside the header");

  // the byte marked last restarts header parsing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last_q) |=> hdr_ctl.hdr_phase)
    else $error("parser did not restart after last byte");

  // input side stalls only while both registers are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a held result");

endmodule

### dv/bmp_pixel_unpacker_unit_tb.sv
// Testbench for bmp_pixel_unpacker_unit: streams BMP files byte by byte and checks every pixel
// and header-status transfer against an in-bench decoder. Depends on bpu_pkg and the RTL top.
`timescale 1ns / 100ps

module bmp_pixel_unpacker_unit_tb;
  import bpu_pkg::*;

  localparam int unsigned MaxWidth      = 4096;
  localparam int unsigned MaxHeight     = 4096;
  localparam int unsigned TotalBytes    = 550;
  localparam int unsigned RandomPixels  = 12;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 2000;

  localparam logic StatPixel   = 1'b0;
  localparam logic StatHdrFail = 1'b1;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [23:0] index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic        status;
  } pix_result_t;

  typedef struct {
    logic [7:0]  sig_b;
    logic [7:0]  sig_m;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [15:0] depth;
    logic [31:0] compression;
  } bmp_hdr_t;

  // Decodes the accepted byte stream and keeps the pixels still owed by the block
  class pixel_scoreboard;
    pix_result_t pixels_due[$];
    int unsigned error_count;
    int unsigned pixels_predicted;

    logic [31:0] bytes_seen;
    logic [31:0] pix_offset;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [31:0] row_num;
    logic [31:0] row_pos;
    logic [31:0] hdr_shift;
    logic [23:0] rgb_hold;
    logic        bgra_mode;
    logic        file_rejected;
    logic        hdr_bad;

    function void clear_file();
      bytes_seen    = '0;
      pix_offset    = '0;
      img_w         = '0;
      img_h         = '0;
      row_num       = '0;
      row_pos       = '0;
      hdr_shift     = '0;
      rgb_hold      = '0;
      bgra_mode     = 1'b0;
      file_rejected = 1'b0;
      hdr_bad       = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] pos, bpp, row_bytes, stride, p, k, col, idx;
      pix_result_t r;
      bit emit;
      pos  = bytes_seen;
      emit = 0;
      r    = '0;
      if (bytes_seen != '1) bytes_seen++;

      if (pos < HdrLen) begin
        hdr_shift = {b, hdr_shift[31:8]};
        case (pos)
          PosSigB: if (b != SigB) hdr_bad = 1'b1;
          PosSigM: if (b != SigM) hdr_bad = 1'b1;
          PosOffset: begin
            pix_offset = hdr_shift;
            if (pix_offset < HdrLen) hdr_bad = 1'b1;
          end
          PosWidth: begin
            if (hdr_shift[31] || hdr_shift > MaxWidth) hdr_bad = 1'b1;
            else img_w = hdr_shift;
          end
          PosHeight: begin
            if (hdr_shift[31] || hdr_shift > MaxHeight) hdr_bad = 1'b1;
            else img_h = hdr_shift;
          end
          PosPlanes: if (hdr_shift[31:16] != PlanesOne) hdr_bad = 1'b1;
          PosDepth: begin
            if (hdr_shift[31:16] == Depth24) bgra_mode = 1'b0;
            else if (hdr_shift[31:16] == Depth32) bgra_mode = 1'b1;
            else hdr_bad = 1'b1;
          end
          PosCompress: if (hdr_shift != BiRgb) hdr_bad = 1'b1;
          PosHdrEnd: begin
            if (hdr_bad) begin
              file_rejected = 1'b1;
              emit          = 1;
              r.status      = StatHdrFail;
            end
          end
          default: ;
        endcase
      end else if (!file_rejected && pos >= pix_offset && row_num < img_h && img_w != 0) begin
        bpp       = bgra_mode ? 32'd4 : 32'd3;
        row_bytes = img_w * bpp;
        stride    = (row_bytes + 32'd3) & ~32'd3;
        p         = row_pos;
        if (p < row_bytes) begin
          k   = p % bpp;
          col = p / bpp;
          // bytes arrive B, G, R (, A); the hold register is R:G:B
          if (k == PhBlue) rgb_hold = {16'h0, b};
          else if (k == PhGreen) rgb_hold[15:8] = b;
          else if (k == PhRed) rgb_hold[23:16] = b;
          if ((k == PhRed && !bgra_mode) || (k == PhAlpha && bgra_mode)) begin
            // rows come bottom-up, the frame index is top-down
            idx         = (img_h - 32'd1 - row_num) * img_w + col;
            emit        = 1;
            r.index     = idx[23:0];
            r.red       = rgb_hold[23:16];
            r.green     = rgb_hold[15:8];
            r.blue      = rgb_hold[7:0];
            r.alpha     = bgra_mode ? b : 8'h00;
            r.has_alpha = bgra_mode;
            r.status    = StatPixel;
          end
        end
        p++;
        if (p >= stride) begin
          p = 0;
          row_num++;
        end
        row_pos = p;
      end

      if (last) begin
        // file ended before the header was complete
        if (pos < PosHdrEnd) begin
          emit     = 1;
          r        = '0;
          r.status = StatHdrFail;
        end
        clear_file();
      end

      if (emit) begin
        pixels_due.push_back(r);
        if (r.status == StatPixel) pixels_predicted++;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_pixel(pix_result_t got);
      pix_result_t want;
      if (pixels_due.size() == 0) begin
        $error("result transfer with nothing pending: index 0x%0h status %0b",
               got.index, got.status);
        error_count++;
        return;
      end
      want = pixels_due.pop_front();
      compare_field("pixel_index", want.index, got.index);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("has_alpha", want.has_alpha, got.has_alpha);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_of_image_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [23:0] pixel_index_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        has_alpha_o;
  logic        status_o;

  pixel_scoreboard unpack_sb;
  int unsigned     bytes_sent;
  int unsigned     stall_cycles;
  bit              tx_burst;
  bit              rx_burst;
  bit              hold_off_req;

  bmp_pixel_unpacker_unit #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_of_image_i(last_of_image_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_index_o  (pixel_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .has_alpha_o    (has_alpha_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both transfers are seen at the rising edge; input first, since its pixel may be due later
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) unpack_sb.note_byte(data_byte_i, last_of_image_i);
      if (out_valid_o && out_ready_i) begin
        unpack_sb.check_pixel({pixel_index_o, red_o, green_o, blue_o, alpha_o,
                               has_alpha_o, status_o});
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("[bmp_pixel_unpacker_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stall per result, burst stretches, and one-off long hold-offs
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall        = HoldOffCycles;
        hold_off_req = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
    end
  end

  // Called at a falling edge; returns at a falling edge with the last byte accepted
  task automatic send_file(input byte_q_t img);
    int unsigned gap;
    foreach (img[i]) begin
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i      <= 1'b1;
      data_byte_i     <= img[i];
      last_of_image_i <= (i == img.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      @(negedge clk_i);
      bytes_sent++;
    end
  endtask

  // Called at a falling edge; stops offering and waits until no result is due
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (unpack_sb.pixels_due.size() != 0);
  endtask

  function automatic bmp_hdr_t plain_hdr(logic [31:0] w, logic [31:0] h, logic [15:0] depth);
    bmp_hdr_t hd;
    hd.sig_b       = SigB;
    hd.sig_m       = SigM;
    hd.offset      = HdrLen;
    hd.width       = w;
    hd.height      = h;
    hd.planes      = PlanesOne;
    hd.depth       = depth;
    hd.compression = BiRgb;
    return hd;
  endfunction

  // Header with random filler, gap up to the offset, padded rows, then trailing junk
  function automatic byte_q_t make_bmp(bmp_hdr_t hd, int unsigned trailing);
    byte_q_t     img;
    logic [7:0]  h[HdrLen];
    logic [31:0] bpp, stride, body, pad;
    foreach (h[i]) h[i] = $urandom;
    h[PosSigB] = hd.sig_b;
    h[PosSigM] = hd.sig_m;
    for (int i = 0; i < 4; i++) begin
      h[PosOffset - 3 + i]   = hd.offset[8*i +: 8];
      h[PosWidth - 3 + i]    = hd.width[8*i +: 8];
      h[PosHeight - 3 + i]   = hd.height[8*i +: 8];
      h[PosCompress - 3 + i] = hd.compression[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      h[PosPlanes - 1 + i] = hd.planes[8*i +: 8];
      h[PosDepth - 1 + i]  = hd.depth[8*i +: 8];
    end
    foreach (h[i]) img.push_back(h[i]);

    pad = (hd.offset >= HdrLen && hd.offset <= HdrLen + 64) ? hd.offset - HdrLen : 0;
    if (!hd.width[31] && !hd.height[31] && hd.width <= MaxWidth && hd.height <= MaxHeight) begin
      bpp    = (hd.depth == Depth32) ? 32'd4 : 32'd3;
      stride = (hd.width * bpp + 32'd3) & ~32'd3;
      body   = hd.height * stride;
    end else begin
      body = $urandom_range(0, 12);
    end
    repeat (pad + body + trailing) img.push_back($urandom);
    return img;
  endfunction

  task automatic run_file(bmp_hdr_t hd, int unsigned trailing, int unsigned cut);
    byte_q_t img;
    img = make_bmp(hd, trailing);
    if (cut > 0 && cut < img.size()) img = img[0:cut-1];
    send_file(img);
  endtask

  task automatic random_file();
    bmp_hdr_t    hd;
    byte_q_t     img;
    int unsigned kind, w, h, trailing;
    logic [15:0] depth;
    kind     = $urandom_range(0, 99);
    trailing = $urandom_range(0, 5);
    w        = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    h        = $urandom_range(0, 4);
    if ($urandom_range(0, 19) == 0) begin
      w = $urandom_range(7, 40);
      h = $urandom_range(1, 3);
    end
    depth = $urandom_range(0, 1) ? Depth32 : Depth24;
    hd    = plain_hdr(w, h, depth);
    if ($urandom_range(0, 2) == 0) hd.offset = HdrLen + $urandom_range(1, 10);

    if (kind < 65) begin
      run_file(hd, trailing, 0);
    end else if (kind < 80) begin
      // one header fault per file
      case ($urandom_range(0, 8))
        0: hd.sig_b = SigB ^ 8'($urandom_range(1, 255));
        1: hd.sig_m = SigM ^ 8'($urandom_range(1, 255));
        2: hd.offset = $urandom_range(0, HdrLen - 1);
        3: hd.planes = $urandom_range(0, 1) ? 16'h0 : 16'($urandom_range(2, 65535));
        4: begin
          hd.depth = $urandom;
          if (hd.depth == Depth24 || hd.depth == Depth32) hd.depth++;
        end
        5: hd.compression = BiRgb + $urandom_range(1, 32'hFFFF_FFFF);
        6: hd.width = $urandom_range(0, 1) ? {1'b1, 31'($urandom)}
                                           : $urandom_range(MaxWidth + 1, 32'h7FFF_FFFF);
        7: hd.height = $urandom_range(0, 1) ? {1'b1, 31'($urandom)}
                                            : $urandom_range(MaxHeight + 1, 32'h7FFF_FFFF);
        default: hd.depth = 16'($urandom_range(1, 23));
      endcase
      run_file(hd, trailing, 0);
    end else if (kind < 90) begin
      // file cut short anywhere, header included
      img = make_bmp(hd, trailing);
      run_file(hd, trailing, $urandom_range(1, img.size()));
    end else begin
      repeat ($urandom_range(1, 70)) img.push_back($urandom);
      if ($urandom_range(0, 1)) begin
        img[0] = SigB;
        if (img.size() > 1) img[1] = SigM;
      end
      send_file(img);
    end
  endtask

  initial begin
    bmp_hdr_t    hd;
    int unsigned pix_start;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    last_of_image_i = 1'b0;
    tx_burst        = 0;
    rx_burst        = 0;
    hold_off_req    = 0;
    bytes_sent      = 0;
    unpack_sb       = new;
    unpack_sb.clear_file();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Good files: 24-bit with row padding, 32-bit with offset gap, single pixel
    run_file(plain_hdr(3, 2, Depth24), 0, 0);
    wait_results_drained();
    hd = plain_hdr(2, 2, Depth32);
    hd.offset = HdrLen + 6;
    run_file(hd, 3, 0);
    run_file(plain_hdr(1, 1, Depth24), 2, 0);

    // Header faults, each flagged once at the header end
    hd = plain_hdr(2, 2, Depth24);  hd.sig_b = 8'h62;                 run_file(hd, 2, 0);
    hd = plain_hdr(2, 2, Depth24);  hd.sig_m = 8'hFF;                 run_file(hd, 2, 0);
    hd = plain_hdr(2, 2, Depth24);  hd.offset = HdrLen - 1;           run_file(hd, 2, 0);
    hd = plain_hdr(2, 2, Depth24);  hd.planes = 16'd2;                run_file(hd, 2, 0);
    hd = plain_hdr(2, 2, Depth24);  hd.depth = 16'hFFFF;              run_file(hd, 2, 0);
    hd = plain_hdr(2, 2, Depth32);  hd.compression = 32'hFFFF_FFFF;   run_file(hd, 2, 0);
    hd = plain_hdr(-3, 2, Depth24);                                   run_file(hd, 2, 0);
    hd = plain_hdr(2, -2, Depth24);                                   run_file(hd, 2, 0);
    hd = plain_hdr(MaxWidth + 1, 1, Depth24);                         run_file(hd, 2, 0);
    hd = plain_hdr(1, MaxHeight + 1, Depth32);                        run_file(hd, 2, 0);

    // Empty images and an offset past the end of the file
    run_file(plain_hdr(0, 3, Depth24), 8, 0);
    run_file(plain_hdr(5, 0, Depth32), 8, 0);
    run_file(plain_hdr(0, MaxHeight, Depth32), 4, 0);
    hd = plain_hdr(2, 2, Depth24);  hd.offset = 32'hFFFF_FFFF;        run_file(hd, 8, 0);

    // Short files: early end, end just before and exactly at the header end
    run_file(plain_hdr(2, 2, Depth24), 0, 11);
    run_file(plain_hdr(2, 2, Depth24), 0, HdrLen - 1);
    run_file(plain_hdr(2, 2, Depth24), 0, HdrLen);
    hd = plain_hdr(2, 2, Depth24);  hd.planes = 16'd0;                run_file(hd, 0, HdrLen);
    run_file(plain_hdr(2, 2, Depth24), 0, 1);
    // pixel stream cut mid-pixel, then a clean file
    run_file(plain_hdr(2, 2, Depth32), 0, HdrLen + 5);
    run_file(plain_hdr(2, 1, Depth32), 0, 0);

    // Sender at full rate while the result side holds off
    wait_results_drained();
    tx_burst     = 1;
    hold_off_req = 1;
    run_file(plain_hdr(16, 2, Depth24), 0, 0);
    tx_burst = 0;

    pix_start = unpack_sb.pixels_predicted;
    while (bytes_sent < TotalBytes ||
           unpack_sb.pixels_predicted - pix_start < RandomPixels) begin
      if ($urandom_range(0, 9) == 0) wait_results_drained();
      if ($urandom_range(0, 29) == 0) hold_off_req = 1;
      tx_burst = ($urandom_range(0, 3) == 0);
      random_file();
    end
    tx_burst = 0;

    wait_results_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (unpack_sb.error_count == 0) begin
      $display("[bmp_pixel_unpacker_unit] OK");
    end else begin
      $display("[bmp_pixel_unpacker_unit] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bpu_pkg.sv
hw/rtl/bpu_hdr.sv
hw/rtl/bpu_walker.sv
hw/rtl/bmp_pixel_unpacker_unit.sv
dv/bmp_pixel_unpacker_unit_tb.sv
